/* hw/rtl/b64d_pkg.sv */
`default_nettype none

package b64d_pkg;

    localparam int CHAR_W  = 8;
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 2;
    localparam int DROP_W  = 16;
    localparam int SEXT_W  = 6;
    localparam int ACC_W   = 18;
    localparam int POS_W   = 2;

    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0a;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0d;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2b;
    localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2f;
    localparam logic [CHAR_W-1:0] CHAR_PAD   = 8'h3d;
    localparam logic [CHAR_W-1:0] CHAR_UC_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UC_Z  = 8'h5a;
    localparam logic [CHAR_W-1:0] CHAR_LC_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LC_Z  = 8'h7a;
    localparam logic [CHAR_W-1:0] CHAR_D0    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_D9    = 8'h39;

    localparam logic [SEXT_W-1:0] SEXT_LC_BASE = 6'd26;
    localparam logic [SEXT_W-1:0] SEXT_D_BASE  = 6'd52;
    localparam logic [SEXT_W-1:0] SEXT_PLUS    = 6'd62;
    localparam logic [SEXT_W-1:0] SEXT_SLASH   = 6'd63;

    localparam logic [POS_W-1:0]   POS_LAST   = 2'd3;
    localparam logic [COUNT_W-1:0] COUNT_FULL = 2'd3;
    localparam logic [DROP_W-1:0]  DROP_MAX   = 16'hffff;

    typedef enum logic [1:0] {
        SYM_DATA,
        SYM_PAD,
        SYM_BAD
    } t_sym_kind;

    typedef struct packed {
        t_sym_kind         kind;
        logic [SEXT_W-1:0] value;
    } t_sym;

    // map one character to its sextet, padding or invalid
    function automatic t_sym sym_decode(input logic [CHAR_W-1:0] c);
        t_sym s;
        logic [CHAR_W-1:0] d;
        s.kind  = SYM_BAD;
        s.value = '0;
        d       = '0;
        if (c >= CHAR_UC_A && c <= CHAR_UC_Z) begin
            d       = c - CHAR_UC_A;
            s.kind  = SYM_DATA;
            s.value = d[SEXT_W-1:0];
        end else if (c >= CHAR_LC_A && c <= CHAR_LC_Z) begin
            d       = c - CHAR_LC_A;
            s.kind  = SYM_DATA;
            s.value = d[SEXT_W-1:0] + SEXT_LC_BASE;
        end else if (c >= CHAR_D0 && c <= CHAR_D9) begin
            d       = c - CHAR_D0;
            s.kind  = SYM_DATA;
            s.value = d[SEXT_W-1:0] + SEXT_D_BASE;
        end else if (c == CHAR_PLUS) begin
            s.kind  = SYM_DATA;
            s.value = SEXT_PLUS;
        end else if (c == CHAR_SLASH) begin
            s.kind  = SYM_DATA;
            s.value = SEXT_SLASH;
        end else if (c == CHAR_PAD) begin
            s.kind  = SYM_PAD;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/b64d_char_if.sv */
`default_nettype none

interface b64d_char_if
    import b64d_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              end_of_data;

    modport source (output valid, output char_code, output end_of_data, input ready);
    modport sink   (input valid, input char_code, input end_of_data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/b64d_byte_if.sv */
`default_nettype none

interface b64d_byte_if
    import b64d_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [BYTE_W-1:0]  byte_hi;
    logic [BYTE_W-1:0]  byte_mid;
    logic [BYTE_W-1:0]  byte_lo;
    logic [COUNT_W-1:0] byte_count;
    logic [DROP_W-1:0]  drop_count;

    modport source (
        output valid, output byte_hi, output byte_mid, output byte_lo,
        output byte_count, output drop_count, input ready
    );
    modport sink (
        input valid, input byte_hi, input byte_mid, input byte_lo,
        input byte_count, input drop_count, output ready
    );
endinterface

`default_nettype wire

/* hw/rtl/base64_line_decoder.sv */
// channel   dir  modport  payload
// i_char    in   sink     char_code[7:0], end_of_data
// o_bytes   out  source   byte_hi, byte_mid, byte_lo, byte_count[1:0], drop_count[15:0]
//
// one character beat is taken per cycle while i_char.ready is high; its result, if any,
// is in the output register on the next cycle
// the decode state and the output register are the only stored elements
// i_char.ready is low only while the output register holds a beat not taken
// synchronous active-low reset clears the decode state and the output valid

`default_nettype none

module base64_line_decoder
    import b64d_pkg::*;
(
    input  wire           i_clk,
    input  wire           i_rst_n,
    b64d_char_if.sink     i_char,
    b64d_byte_if.source   o_bytes
);

    // decode state
    logic [ACC_W-1:0]  r_acc,  n_acc;
    logic [POS_W-1:0]  r_pos,  n_pos;
    logic [POS_W-1:0]  r_pad,  n_pad;
    logic              r_skip, n_skip;
    logic [DROP_W-1:0] r_line, n_line;

    // output register
    logic               r_out_valid;
    logic [BYTE_W-1:0]  r_hi,  n_hi;
    logic [BYTE_W-1:0]  r_mid, n_mid;
    logic [BYTE_W-1:0]  r_lo,  n_lo;
    logic [COUNT_W-1:0] r_cnt, n_cnt;
    logic [DROP_W-1:0]  r_drop, n_drop;
    logic               n_emit;

    logic   in_ready;
    logic   accept;
    t_sym   sym;
    logic [DROP_W:0] line_sum;

    assign in_ready     = !r_out_valid || o_bytes.ready;
    assign accept       = i_char.valid && in_ready;
    assign i_char.ready = in_ready;
    assign sym          = sym_decode(i_char.char_code);

    // per-character decode, then the end-of-data flush
    always_comb begin
        n_acc    = r_acc;
        n_pos    = r_pos;
        n_pad    = r_pad;
        n_skip   = r_skip;
        n_line   = r_line;
        n_emit   = 1'b0;
        n_hi     = '0;
        n_mid    = '0;
        n_lo     = '0;
        n_cnt    = '0;
        n_drop   = '0;
        line_sum = '0;

        if (i_char.char_code == CHAR_LF || i_char.char_code == CHAR_CR) begin
            n_skip = 1'b0;
            n_line = '0;
        end else if (r_skip) begin
            n_skip = 1'b1;
        end else if (r_pad != '0) begin
            n_pad = r_pad - 1'b1;
        end else begin
            case (sym.kind)
                SYM_BAD: begin
                    n_emit = 1'b1;
                    n_drop = r_line;
                    n_line = '0;
                    n_acc  = '0;
                    n_pos  = '0;
                    n_skip = 1'b1;
                end
                SYM_PAD: begin
                    n_pad = POS_LAST - r_pos;
                    // flush happens below with the shared partial path
                end
                SYM_DATA: begin
                    if (r_pos == POS_LAST) begin
                        n_emit = 1'b1;
                        n_hi   = r_acc[17:10];
                        n_mid  = r_acc[9:2];
                        n_lo   = {r_acc[1:0], sym.value};
                        n_cnt  = COUNT_FULL;
                        n_acc  = '0;
                        n_pos  = '0;
                    end else begin
                        n_acc = {r_acc[ACC_W-SEXT_W-1:0], sym.value};
                        n_pos = r_pos + 1'b1;
                    end
                end
                default: begin
                    n_emit = 1'b0;
                end
            endcase
        end

        // partial quartet flush on padding, or on end of data with no result yet
        if ((!r_skip && r_pad == '0 && sym.kind == SYM_PAD
                && i_char.char_code != CHAR_LF && i_char.char_code != CHAR_CR)
                || (i_char.end_of_data && !n_emit)) begin
            if (n_pos == 2'd2) begin
                n_emit = 1'b1;
                n_hi   = n_acc[11:4];
                n_cnt  = 2'd1;
            end else if (n_pos == POS_LAST) begin
                n_emit = 1'b1;
                n_hi   = n_acc[17:10];
                n_mid  = n_acc[9:2];
                n_cnt  = 2'd2;
            end
            n_acc = '0;
            n_pos = '0;
        end

        // saturating count of bytes on the current line
        line_sum = {1'b0, n_line} + {{(DROP_W-1){1'b0}}, n_cnt};
        n_line   = line_sum[DROP_W] ? DROP_MAX : line_sum[DROP_W-1:0];

        if (i_char.end_of_data) begin
            n_acc  = '0;
            n_pos  = '0;
            n_pad  = '0;
            n_skip = 1'b0;
            n_line = '0;
        end
    end

    // state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_pos       <= '0;
            r_pad       <= '0;
            r_skip      <= 1'b0;
            r_line      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_acc  <= n_acc;
                r_pos  <= n_pos;
                r_pad  <= n_pad;
                r_skip <= n_skip;
                r_line <= n_line;
            end
            if (in_ready) begin
                r_out_valid <= accept && n_emit;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (accept && n_emit) begin
            r_hi   <= n_hi;
            r_mid  <= n_mid;
            r_lo   <= n_lo;
            r_cnt  <= n_cnt;
            r_drop <= n_drop;
        end
    end

    assign o_bytes.valid      = r_out_valid;
    assign o_bytes.byte_hi    = r_hi;
    assign o_bytes.byte_mid   = r_mid;
    assign o_bytes.byte_lo    = r_lo;
    assign o_bytes.byte_count = r_cnt;
    assign o_bytes.drop_count = r_drop;

endmodule

`default_nettype wire

/* test/tb_base64_line_decoder.sv */
`timescale 1ns / 100ps

module tb_base64_line_decoder;
    import b64d_pkg::*;

    typedef struct {
        logic [BYTE_W-1:0]  byte_hi;
        logic [BYTE_W-1:0]  byte_mid;
        logic [BYTE_W-1:0]  byte_lo;
        logic [COUNT_W-1:0] byte_count;
        logic [DROP_W-1:0]  drop_count;
    } t_decoded_beat;

    logic i_clk;
    logic i_rst_n;

    b64d_char_if char_bus ();
    b64d_byte_if byte_bus ();

    base64_line_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (char_bus),
        .o_bytes (byte_bus)
    );

    // decoder state as predicted
    logic [ACC_W-1:0]  pend_sextets;
    logic [POS_W-1:0]  pend_count;
    logic [POS_W-1:0]  pad_left;
    bit                line_skip;
    logic [DROP_W-1:0] line_bytes;

    t_decoded_beat decoded_q[$];

    int src_gap_pct;
    int sink_stall_pct;
    int chars_sent;
    int beats_seen;
    int retractions_seen;
    int mismatches;

    // clock, period 4 ns
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // hard stop in case the handshake hangs
    initial begin
        #2_000_000;
        $display("tb_base64_line_decoder failed");
        $finish;
    end

    // output side back-pressure
    always @(negedge i_clk) begin
        byte_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // map a character to its sextet, padding or invalid
    function automatic t_sym classify_char(input logic [CHAR_W-1:0] c);
        t_sym r;
        r.kind  = SYM_DATA;
        r.value = '0;
        if (c >= CHAR_UC_A && c <= CHAR_UC_Z)
            r.value = SEXT_W'(c - CHAR_UC_A);
        else if (c >= CHAR_LC_A && c <= CHAR_LC_Z)
            r.value = SEXT_W'(c - CHAR_LC_A) + SEXT_LC_BASE;
        else if (c >= CHAR_D0 && c <= CHAR_D9)
            r.value = SEXT_W'(c - CHAR_D0) + SEXT_D_BASE;
        else if (c == CHAR_PLUS)
            r.value = SEXT_PLUS;
        else if (c == CHAR_SLASH)
            r.value = SEXT_SLASH;
        else if (c == CHAR_PAD)
            r.kind = SYM_PAD;
        else
            r.kind = SYM_BAD;
        return r;
    endfunction

    function automatic logic [CHAR_W-1:0] pick_b64_char();
        int v;
        v = $urandom_range(63);
        if (v < 26) return CHAR_UC_A + CHAR_W'(v);
        if (v < 52) return CHAR_LC_A + CHAR_W'(v - 26);
        if (v < 62) return CHAR_D0 + CHAR_W'(v - 52);
        if (v == 62) return CHAR_PLUS;
        return CHAR_SLASH;
    endfunction

    // any byte that is neither alphabet, padding nor line break
    function automatic logic [CHAR_W-1:0] pick_bad_char();
        logic [CHAR_W-1:0] c;
        c = CHAR_W'($urandom_range(255));
        while (classify_char(c).kind != SYM_BAD || c == CHAR_LF || c == CHAR_CR)
            c = CHAR_W'($urandom_range(255));
        return c;
    endfunction

    function automatic void reset_decoder();
        pend_sextets = '0;
        pend_count   = '0;
        pad_left     = '0;
        line_skip    = 1'b0;
        line_bytes   = '0;
    endfunction

    function automatic void add_line_bytes(input int n);
        if (int'(line_bytes) + n > int'(DROP_MAX))
            line_bytes = DROP_MAX;
        else
            line_bytes = line_bytes + DROP_W'(n);
    endfunction

    function automatic t_decoded_beat make_beat(input logic [23:0] word,
                                                input logic [COUNT_W-1:0] cnt,
                                                input logic [DROP_W-1:0] drop);
        t_decoded_beat b;
        b.byte_hi    = (cnt >= 1) ? word[23:16] : '0;
        b.byte_mid   = (cnt >= 2) ? word[15:8] : '0;
        b.byte_lo    = (cnt >= 3) ? word[7:0] : '0;
        b.byte_count = cnt;
        b.drop_count = drop;
        return b;
    endfunction

    // emit the partial quartet: k pending sextets give k-1 bytes
    function automatic bit flush_pending(output t_decoded_beat b);
        logic [23:0] word;
        bit          got;
        word = (pend_count == 2'd2) ? {pend_sextets[11:0], 12'd0} : {pend_sextets, 6'd0};
        got  = (pend_count >= 2'd2);
        b    = make_beat(word, pend_count - 2'd1, '0);
        if (got)
            add_line_bytes(int'(pend_count) - 1);
        pend_sextets = '0;
        pend_count   = '0;
        return got;
    endfunction

    // advance the predicted decoder by one character beat
    function automatic void decode_char(input logic [CHAR_W-1:0] c, input logic eod);
        t_sym          s;
        t_decoded_beat b;
        bit            got;
        got = 1'b0;
        if (c == CHAR_LF || c == CHAR_CR) begin
            line_skip  = 1'b0;
            line_bytes = '0;
        end else if (line_skip) begin
            // rest of a bad line is dropped
        end else if (pad_left != '0) begin
            pad_left = pad_left - 2'd1;
        end else begin
            s = classify_char(c);
            if (s.kind == SYM_BAD) begin
                b            = make_beat('0, '0, line_bytes);
                got          = 1'b1;
                line_bytes   = '0;
                pend_sextets = '0;
                pend_count   = '0;
                line_skip    = 1'b1;
            end else if (s.kind == SYM_PAD) begin
                pad_left = 2'd3 - pend_count;
                got      = flush_pending(b);
            end else if (pend_count == POS_LAST) begin
                b = make_beat({pend_sextets, s.value}, COUNT_FULL, '0);
                add_line_bytes(3);
                got          = 1'b1;
                pend_sextets = '0;
                pend_count   = '0;
            end else begin
                pend_sextets = {pend_sextets[11:0], s.value};
                pend_count   = pend_count + 2'd1;
            end
        end
        // end of data flushes whatever is pending, then back to reset
        if (eod) begin
            if (!got)
                got = flush_pending(b);
            reset_decoder();
        end
        if (got)
            decoded_q.push_back(b);
    endfunction

    function automatic void check_field(input string what, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            mismatches++;
        end
    endfunction

    // compare each output beat with the oldest prediction
    always @(posedge i_clk) begin
        t_decoded_beat want;
        if (i_rst_n && byte_bus.valid && byte_bus.ready) begin
            beats_seen++;
            if (byte_bus.byte_count == '0)
                retractions_seen++;
            if (decoded_q.size() == 0) begin
                $display("%0t ns: unexpected beat, actual %h %h %h count %0d drop %0d",
                         $time, byte_bus.byte_hi, byte_bus.byte_mid, byte_bus.byte_lo,
                         byte_bus.byte_count, byte_bus.drop_count);
                mismatches++;
            end else begin
                want = decoded_q.pop_front();
                check_field("byte_hi", want.byte_hi, byte_bus.byte_hi);
                check_field("byte_mid", want.byte_mid, byte_bus.byte_mid);
                check_field("byte_lo", want.byte_lo, byte_bus.byte_lo);
                check_field("byte_count", want.byte_count, byte_bus.byte_count);
                check_field("drop_count", want.drop_count, byte_bus.drop_count);
            end
        end
    end

    // drive one character beat; entered and left just after a falling edge
    task automatic send_char(input logic [CHAR_W-1:0] c, input logic eod);
        while ($urandom_range(99) < src_gap_pct) begin
            char_bus.valid = 1'b0;
            @(negedge i_clk);
        end
        char_bus.valid       = 1'b1;
        char_bus.char_code   = c;
        char_bus.end_of_data = eod;
        @(posedge i_clk);
        while (!char_bus.ready)
            @(posedge i_clk);
        decode_char(c, eod);
        chars_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s, input bit eod_last);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], eod_last && (i == s.len() - 1));
    endtask

    task automatic send_chars(ref logic [CHAR_W-1:0] q[$], input bit eod_last);
        for (int i = 0; i < q.size(); i++)
            send_char(q[i], eod_last && (i == q.size() - 1));
    endtask

    task automatic test_directed();
        // alphabet extremes in two full quartets
        send_text("//+AZaz0", 1'b0);
        // bad byte retracts the six bytes, rest of line skipped
        send_char(8'hff, 1'b0);
        send_text("x\r", 1'b0);
        // bad byte with nothing emitted on the line
        send_char(8'h80, 1'b0);
        send_char(CHAR_LF, 1'b0);
        // quartet spanning a line break, padding after three sextets
        send_text("QU\nI=", 1'b0);
        // early padding, then two ignored positions of any value
        send_text("Q=", 1'b0);
        send_char(8'h00, 1'b0);
        send_char(CHAR_PAD, 1'b0);
        // end of data flushes a pair, and a full quartet leaves nothing
        send_text("QQ", 1'b1);
        send_text("QUJD", 1'b1);
    endtask

    // mostly well-formed lines with random content, some bad lines and noise
    task automatic test_random_text(input int n);
        logic [CHAR_W-1:0] line[$];
        int                start;
        int                pick;
        int                brk;
        bit                eod_end;
        start = chars_sent;
        while (chars_sent - start < n) begin
            line.delete();
            pick    = $urandom_range(99);
            eod_end = ($urandom_range(9) == 0);
            if (pick < 70) begin
                repeat ($urandom_range(6) * 4)
                    line.push_back(pick_b64_char());
                case ($urandom_range(4))
                    1: begin
                        repeat (2) line.push_back(pick_b64_char());
                        repeat (2) line.push_back(CHAR_PAD);
                    end
                    2: begin
                        repeat (3) line.push_back(pick_b64_char());
                        line.push_back(CHAR_PAD);
                    end
                    3: repeat ($urandom_range(1, 3)) line.push_back(pick_b64_char());
                    4: begin
                        line.push_back(pick_b64_char());
                        line.push_back(CHAR_PAD);
                        repeat (2) line.push_back(CHAR_W'($urandom_range(255)));
                    end
                    default: ;
                endcase
            end else if (pick < 85) begin
                repeat ($urandom_range(10)) line.push_back(pick_b64_char());
                line.push_back(pick_bad_char());
                repeat ($urandom_range(1, 4)) line.push_back(CHAR_W'($urandom_range(255)));
            end else begin
                repeat ($urandom_range(1, 5)) line.push_back(CHAR_W'($urandom_range(255)));
            end
            if (eod_end) begin
                if (line.size() == 0)
                    line.push_back(pick_b64_char());
            end else begin
                brk = $urandom_range(2);
                if (brk != 0)
                    line.push_back(CHAR_CR);
                if (brk != 2)
                    line.push_back(CHAR_LF);
            end
            send_chars(line, eod_end);
        end
    endtask

    initial begin
        i_rst_n              = 1'b0;
        char_bus.valid       = 1'b0;
        char_bus.char_code   = '0;
        char_bus.end_of_data = 1'b0;
        byte_bus.ready       = 1'b0;
        src_gap_pct          = 0;
        sink_stall_pct       = 0;
        chars_sent           = 0;
        beats_seen           = 0;
        retractions_seen     = 0;
        mismatches           = 0;
        reset_decoder();

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // sender idles lightly, receiver stalls heavily
        src_gap_pct    = 10;
        sink_stall_pct = 56;
        test_directed();
        test_random_text(220);

        // the other way round
        src_gap_pct    = 56;
        sink_stall_pct = 10;
        test_random_text(220);

        // full rate both sides
        src_gap_pct    = 0;
        sink_stall_pct = 0;
        test_random_text(200);

        char_bus.valid = 1'b0;
        while (decoded_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("sent %0d characters under three pacing mixes, directed and random lines",
                 chars_sent);
        $display("checked %0d output beats, %0d of them retractions",
                 beats_seen, retractions_seen);
        if (mismatches == 0) begin
            $display("tb_base64_line_decoder passed");
        end else begin
            $display("tb_base64_line_decoder failed");
        end
        $finish;
    end

endmodule
